FILE: sv/tfd_pkg.sv
// Shared constants, codes and types for the serial device with byte queues.
package tfd_pkg;

    localparam int FIFO_DEPTH = 256;
    localparam int RATE_SHIFT = 4;

    localparam int BYTE_W = 8;
    localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int RATE_W = 3;
    // wide enough for the queue count plus one and for the byte limit
    localparam int CMP_W  = ((CNT_W > BYTE_W) ? CNT_W : BYTE_W) + 1;

    localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'd255;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [BYTE_W-1:0] ADDR_CTRL     = 8'd0;
    localparam logic [BYTE_W-1:0] ADDR_RX_COUNT = 8'd1;
    localparam logic [BYTE_W-1:0] ADDR_TX_COUNT = 8'd2;
    localparam logic [BYTE_W-1:0] ADDR_DATA     = 8'd3;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [BYTE_W-1:0] data;
    } t_q_req;

endpackage

FILE: sv/tfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/tfd_queue.sv
// One byte ring queue: head and count registers over a RAM, with drop-oldest at the limit.
module tfd_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tfd_pkg::t_q_req             i_req,
    input  logic [tfd_pkg::BYTE_W-1:0]  i_limit,
    output logic [tfd_pkg::CNT_W-1:0]   o_count,
    output logic [tfd_pkg::BYTE_W-1:0]  o_rd_data
);

    logic [tfd_pkg::PTR_W-1:0] r_head;
    logic [tfd_pkg::PTR_W-1:0] n_head;
    logic [tfd_pkg::CNT_W-1:0] r_count;
    logic [tfd_pkg::CNT_W-1:0] n_count;

    logic [tfd_pkg::PTR_W-1:0] head_inc;
    logic [tfd_pkg::CNT_W:0]   tail_sum;
    logic [tfd_pkg::PTR_W-1:0] tail_addr;
    logic [tfd_pkg::CMP_W-1:0] lim_eff;
    logic [tfd_pkg::CMP_W-1:0] count_plus;

    always_comb begin
        head_inc = (r_head == tfd_pkg::PTR_W'(tfd_pkg::FIFO_DEPTH - 1))
                 ? '0 : r_head + 1'b1;

        // ring slot behind the newest byte
        tail_sum = (tfd_pkg::CNT_W + 1)'(r_head) + (tfd_pkg::CNT_W + 1)'(r_count);
        if (tail_sum >= (tfd_pkg::CNT_W + 1)'(tfd_pkg::FIFO_DEPTH)) begin
            tail_addr = tfd_pkg::PTR_W'(tail_sum - (tfd_pkg::CNT_W + 1)'(tfd_pkg::FIFO_DEPTH));
        end else begin
            tail_addr = tfd_pkg::PTR_W'(tail_sum);
        end

        lim_eff = tfd_pkg::CMP_W'(i_limit);
        if (lim_eff > tfd_pkg::CMP_W'(tfd_pkg::FIFO_DEPTH)) begin
            lim_eff = tfd_pkg::CMP_W'(tfd_pkg::FIFO_DEPTH);
        end
        count_plus = tfd_pkg::CMP_W'(r_count) + 1'b1;

        n_head  = r_head;
        n_count = r_count;
        if (i_req.push) begin
            // at the limit the oldest byte goes: head advances, count holds
            if (count_plus >= lim_eff) begin
                n_head = head_inc;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else if (i_req.pop) begin
            n_head  = head_inc;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    tfd_ram #(
        .WIDTH (tfd_pkg::BYTE_W),
        .DEPTH (tfd_pkg::FIFO_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_req.push),
        .i_wr_addr (tail_addr),
        .i_wr_data (i_req.data),
        .i_rd_en   (i_req.pop),
        .i_rd_addr (r_head),
        .o_rd_data (o_rd_data)
    );

    assign o_count = r_count;

endmodule

FILE: sv/tty_fifo_device.sv
// Top level of the terminal-style serial device with receive and transmit byte queues.
//
// Each input word is a bus read, a bus write or a byte-time tick, and yields
// exactly one result word. In the accept cycle the queue pointers and counts
// update and the queue RAM write or read is issued; in the next cycle the
// registered RAM read data is captured into the output register. The
// registered read of the queue RAMs sets this split, and the block takes no
// new word while one is in flight. The output register frees the input side
// as soon as the previous result is taken. Queue RAMs need no clearing after
// reset: only entries below the count are ever read. The fifo_limit register
// (reset 255) is written through i_cfg_wr_en/i_cfg_wr_data and applies to
// both queues.
module tty_fifo_device (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    // input words
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_address,
    input  logic [7:0] i_write_data,
    input  logic       i_rx_valid,
    input  logic [7:0] i_rx_byte,
    // result words
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_bad_address
);

    // configuration and control register state
    logic [tfd_pkg::BYTE_W-1:0] r_fifo_limit;
    logic                       r_port_en;
    logic                       n_port_en;
    logic [tfd_pkg::RATE_W-1:0] r_rate;
    logic [tfd_pkg::RATE_W-1:0] n_rate;

    // word in flight: set in the accept cycle, resolved in the next cycle
    logic                       r_busy;
    logic                       r_pend_rx_pop;
    logic                       n_pend_rx_pop;
    logic [tfd_pkg::BYTE_W-1:0] r_pend_rdata;
    logic [tfd_pkg::BYTE_W-1:0] n_pend_rdata;
    logic                       r_pend_txv;
    logic                       n_pend_txv;
    logic                       r_pend_bad;
    logic                       n_pend_bad;

    // output register
    logic                       r_out_valid;
    logic [tfd_pkg::BYTE_W-1:0] r_read_data;
    logic                       r_tx_valid;
    logic [tfd_pkg::BYTE_W-1:0] r_tx_byte;
    logic                       r_bad_address;

    logic                       in_accept;
    logic                       out_take;
    tfd_pkg::t_op               op;
    tfd_pkg::t_q_req            rx_req;
    tfd_pkg::t_q_req            tx_req;
    logic [tfd_pkg::CNT_W-1:0]  rx_count;
    logic [tfd_pkg::CNT_W-1:0]  tx_count;
    logic [tfd_pkg::BYTE_W-1:0] rx_rd_data;
    logic [tfd_pkg::BYTE_W-1:0] tx_rd_data;
    logic                       addr_bad;

    // Stall while a word is in flight, or while a finished result is held back.
    assign o_in_stall = r_busy || (r_out_valid && i_out_stall);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;

    assign op       = tfd_pkg::t_op'(i_operation);
    assign addr_bad = (i_address > tfd_pkg::ADDR_DATA);

    // Decode the accepted word: queue requests, control updates and the
    // parts of the result that do not depend on RAM read data.
    always_comb begin
        rx_req        = '0;
        tx_req        = '0;
        n_port_en     = r_port_en;
        n_rate        = r_rate;
        n_pend_rx_pop = 1'b0;
        n_pend_rdata  = '0;
        n_pend_txv    = 1'b0;
        n_pend_bad    = 1'b0;

        if (in_accept) begin
            case (op)
                tfd_pkg::OP_READ: begin
                    if (addr_bad) begin
                        n_pend_bad = 1'b1;
                    end else if (i_address == tfd_pkg::ADDR_CTRL) begin
                        n_pend_rdata = tfd_pkg::BYTE_W'(r_port_en)
                                     | (tfd_pkg::BYTE_W'(r_rate) << tfd_pkg::RATE_SHIFT);
                    end else if (i_address == tfd_pkg::ADDR_RX_COUNT) begin
                        n_pend_rdata = tfd_pkg::BYTE_W'(rx_count);
                    end else if (i_address == tfd_pkg::ADDR_TX_COUNT) begin
                        n_pend_rdata = tfd_pkg::BYTE_W'(tx_count);
                    end else begin
                        // data port: pop a receive byte, empty queue reads 0
                        if (rx_count != '0) begin
                            rx_req.pop    = 1'b1;
                            n_pend_rx_pop = 1'b1;
                        end
                    end
                end
                tfd_pkg::OP_WRITE: begin
                    if (addr_bad) begin
                        n_pend_bad = 1'b1;
                    end else if (i_address == tfd_pkg::ADDR_CTRL) begin
                        n_port_en = i_write_data[0];
                        n_rate    = tfd_pkg::RATE_W'(i_write_data >> tfd_pkg::RATE_SHIFT);
                    end else if (i_address == tfd_pkg::ADDR_DATA) begin
                        tx_req.push = 1'b1;
                        tx_req.data = i_write_data;
                    end
                    // count registers ignore writes
                end
                tfd_pkg::OP_TICK: begin
                    // send one queued byte when enabled, take one arriving byte
                    if (r_port_en && (tx_count != '0)) begin
                        tx_req.pop = 1'b1;
                        n_pend_txv = 1'b1;
                    end
                    if (i_rx_valid) begin
                        rx_req.push = 1'b1;
                        rx_req.data = i_rx_byte;
                    end
                end
                default: begin
                    // no effect, all-zero result
                end
            endcase
        end
    end

    tfd_queue u_rx_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (rx_req),
        .i_limit   (r_fifo_limit),
        .o_count   (rx_count),
        .o_rd_data (rx_rd_data)
    );

    tfd_queue u_tx_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tx_req),
        .i_limit   (r_fifo_limit),
        .o_count   (tx_count),
        .o_rd_data (tx_rd_data)
    );

    // Control state, the in-flight flag and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo_limit <= tfd_pkg::LIMIT_RESET;
            r_port_en    <= 1'b0;
            r_rate       <= '0;
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_fifo_limit <= i_cfg_wr_data;
            end
            r_port_en <= n_port_en;
            r_rate    <= n_rate;
            r_busy    <= in_accept;
            // load when the in-flight word resolves, drop once taken
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pending result fields and the output payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pend_rx_pop <= n_pend_rx_pop;
            r_pend_rdata  <= n_pend_rdata;
            r_pend_txv    <= n_pend_txv;
            r_pend_bad    <= n_pend_bad;
        end
        if (r_busy) begin
            r_read_data   <= r_pend_rx_pop ? rx_rd_data : r_pend_rdata;
            r_tx_valid    <= r_pend_txv;
            r_tx_byte     <= r_pend_txv ? tx_rd_data : '0;
            r_bad_address <= r_pend_bad;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_read_data;
    assign o_tx_valid    = r_tx_valid;
    assign o_tx_byte     = r_tx_byte;
    assign o_bad_address = r_bad_address;

endmodule

FILE: verif/tty_fifo_device_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the serial device with receive and transmit byte queues.
module tty_fifo_device_tb;

    localparam int CLK_PERIOD    = 12;
    // settle margin after the last word, before a limit write
    localparam int SETTLE_CYCLES = 4;

    // One result word as the block presents it
    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       bad_address;
    } t_tty_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [7:0] i_cfg_wr_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_operation;
    logic [7:0] i_address;
    logic [7:0] i_write_data;
    logic       i_rx_valid;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_read_data;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_bad_address;

    // Shadow of the device: both queues as plain byte lists, control and limit
    logic [7:0]  rx_bytes[$];
    logic [7:0]  tx_bytes[$];
    logic        port_on;
    logic [2:0]  rate_sel;
    logic [7:0]  fifo_limit;

    // Result words still owed by the device, oldest first
    t_tty_result expected_results[$];

    int   mismatches       = 0;
    int   in_gap_max       = 12;
    int   out_gap_max      = 12;
    int   hold_off_request = 0;
    logic offering         = 1'b0;

    tty_fifo_device dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .i_rx_valid    (i_rx_valid),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_data   (o_read_data),
        .o_tx_valid    (o_tx_valid),
        .o_tx_byte     (o_tx_byte),
        .o_bad_address (o_bad_address)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Push one byte into a shadow queue. The push lands first; if that brings
    // the count to the limit in force, the oldest byte falls out, so a limit
    // of one keeps the queue permanently empty.
    function automatic void push_byte(logic to_rx, logic [7:0] b);
        int lim;
        lim = (int'(fifo_limit) > tfd_pkg::FIFO_DEPTH) ? tfd_pkg::FIFO_DEPTH
                                                       : int'(fifo_limit);
        if (to_rx) begin
            if (rx_bytes.size() >= tfd_pkg::FIFO_DEPTH) void'(rx_bytes.pop_front());
            rx_bytes.push_back(b);
            if (rx_bytes.size() >= lim) void'(rx_bytes.pop_front());
        end else begin
            if (tx_bytes.size() >= tfd_pkg::FIFO_DEPTH) void'(tx_bytes.pop_front());
            tx_bytes.push_back(b);
            if (tx_bytes.size() >= lim) void'(tx_bytes.pop_front());
        end
    endfunction

    // Advance the shadow by one accepted word and return the result it owes.
    function automatic t_tty_result predict_result(tfd_pkg::t_op op, logic [7:0] addr,
                                                   logic [7:0] wdata, logic rxv,
                                                   logic [7:0] rxb);
        t_tty_result r;
        r = '0;
        case (op)
            tfd_pkg::OP_READ: begin
                if (addr == tfd_pkg::ADDR_CTRL) begin
                    r.read_data = {7'd0, port_on}
                                | ({5'd0, rate_sel} << tfd_pkg::RATE_SHIFT);
                end else if (addr == tfd_pkg::ADDR_RX_COUNT) begin
                    r.read_data = 8'(rx_bytes.size());
                end else if (addr == tfd_pkg::ADDR_TX_COUNT) begin
                    r.read_data = 8'(tx_bytes.size());
                end else if (addr == tfd_pkg::ADDR_DATA) begin
                    // an empty receive queue reads as zero and stays empty
                    if (rx_bytes.size() != 0) r.read_data = rx_bytes.pop_front();
                end else begin
                    r.bad_address = 1'b1;
                end
            end
            tfd_pkg::OP_WRITE: begin
                if (addr == tfd_pkg::ADDR_CTRL) begin
                    port_on  = wdata[0];
                    rate_sel = wdata[tfd_pkg::RATE_SHIFT +: tfd_pkg::RATE_W];
                end else if (addr == tfd_pkg::ADDR_DATA) begin
                    push_byte(1'b0, wdata);
                end else if (addr > tfd_pkg::ADDR_DATA) begin
                    r.bad_address = 1'b1;
                end
                // writes to either count register fall through untouched
            end
            tfd_pkg::OP_TICK: begin
                // send before receive; a disabled port still receives
                if (port_on && tx_bytes.size() != 0) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = tx_bytes.pop_front();
                end
                if (rxv) push_byte(1'b1, rxb);
            end
            default: ;
        endcase
        return r;
    endfunction

    // Drop the offer, but only if one is up, so valid never sees two
    // assignments in one step.
    task automatic lower_valid();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Offer one word after a random gap and hold it until the block takes it.
    // Valid is left high on return so that back-to-back words need no gap.
    task automatic send_word(tfd_pkg::t_op op, logic [7:0] addr, logic [7:0] wdata,
                             logic rxv, logic [7:0] rxb);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            lower_valid();
            repeat (gap) @(posedge i_clk);
        end
        i_operation  <= op;
        i_address    <= addr;
        i_write_data <= wdata;
        i_rx_valid   <= rxv;
        i_rx_byte    <= rxb;
        if (!offering) begin
            i_in_valid <= 1'b1;
            offering = 1'b1;
        end
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(predict_result(op, addr, wdata, rxv, rxb));
    endtask

    // Withdraw the offer, wait for every owed result, then let the pipe settle.
    task automatic wait_for_results();
        lower_valid();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the queue limit only once the block has gone quiet.
    task automatic set_fifo_limit(logic [7:0] value);
        wait_for_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        fifo_limit = value;
    endtask

    // Draw one word, weighted towards well-formed traffic on the data port
    // and byte ticks, with a share of stray addresses and dead operations.
    task automatic send_random_word();
        int           pick;
        tfd_pkg::t_op op;
        logic [7:0]   addr;
        logic [7:0]   wdata;
        logic [7:0]   rxb;
        logic         rxv;
        pick  = $urandom_range(0, 99);
        addr  = 8'($urandom);
        wdata = 8'($urandom);
        rxb   = 8'($urandom);
        rxv   = 1'($urandom);
        op    = tfd_pkg::OP_NONE;
        if (pick < 28) begin
            op   = tfd_pkg::OP_WRITE;
            addr = tfd_pkg::ADDR_DATA;
        end else if (pick < 55) begin
            op  = tfd_pkg::OP_TICK;
            rxv = ($urandom_range(0, 3) != 0);
        end else if (pick < 72) begin
            op   = tfd_pkg::OP_READ;
            addr = tfd_pkg::ADDR_DATA;
        end else if (pick < 80) begin
            op   = tfd_pkg::OP_READ;
            addr = ($urandom_range(0, 1) != 0) ? tfd_pkg::ADDR_RX_COUNT
                                               : tfd_pkg::ADDR_TX_COUNT;
        end else if (pick < 82) begin
            op   = tfd_pkg::OP_READ;
            addr = tfd_pkg::ADDR_CTRL;
        end else if (pick < 86) begin
            // keep the port mostly enabled so the transmit side moves
            op       = tfd_pkg::OP_WRITE;
            addr     = tfd_pkg::ADDR_CTRL;
            wdata[0] = ($urandom_range(0, 4) != 0);
        end else if (pick < 89) begin
            op   = tfd_pkg::OP_WRITE;
            addr = ($urandom_range(0, 1) != 0) ? tfd_pkg::ADDR_RX_COUNT
                                               : tfd_pkg::ADDR_TX_COUNT;
        end else if (pick < 97) begin
            // any address at all, so mostly out of range
            op = ($urandom_range(0, 1) != 0) ? tfd_pkg::OP_READ : tfd_pkg::OP_WRITE;
        end
        send_word(op, addr, wdata, rxv, rxb);
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
            mismatches++;
        end
    endtask

    // Take result words, compare each with the oldest expectation, and drive
    // the output stall: a random wait after every word, or a long hold-off
    // when one is requested.
    initial begin : result_checker
        t_tty_result want;
        int          stall_left;
        logic        taken;
        stall_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            taken = i_rst_n && (o_out_valid === 1'b1) && !i_out_stall;
            if (taken) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no expectation waiting");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.read_data, o_read_data);
                    check_field("tx_valid", {7'd0, want.tx_valid}, {7'd0, o_tx_valid});
                    check_field("tx_byte", want.tx_byte, o_tx_byte);
                    check_field("bad_address", {7'd0, want.bad_address},
                                {7'd0, o_bad_address});
                end
            end
            if (hold_off_request > 0) begin
                stall_left       = hold_off_request;
                hold_off_request = 0;
            end else if (taken) begin
                stall_left = $urandom_range(0, out_gap_max);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_out_stall <= (stall_left > 0);
        end
    end

    // Registers straight out of reset, including a read of the empty queue.
    task automatic test_reset_state();
        send_word(tfd_pkg::OP_READ, tfd_pkg::ADDR_CTRL, 8'h00, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_READ, tfd_pkg::ADDR_RX_COUNT, 8'h00, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_READ, tfd_pkg::ADDR_TX_COUNT, 8'h00, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_READ, tfd_pkg::ADDR_DATA, 8'h00, 1'b0, 8'h00);
    endtask

    // Control fields, ignored count writes, stray addresses, dead operation.
    task automatic test_register_access();
        send_word(tfd_pkg::OP_WRITE, tfd_pkg::ADDR_CTRL, 8'hFF, 1'b1, 8'hFF);
        send_word(tfd_pkg::OP_READ, tfd_pkg::ADDR_CTRL, 8'h00, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_WRITE, tfd_pkg::ADDR_CTRL, 8'h00, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_READ, tfd_pkg::ADDR_CTRL, 8'hFF, 1'b1, 8'hFF);
        send_word(tfd_pkg::OP_WRITE, tfd_pkg::ADDR_RX_COUNT, 8'hAA, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_WRITE, tfd_pkg::ADDR_TX_COUNT, 8'h55, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_READ, 8'hFF, 8'h00, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_WRITE, tfd_pkg::ADDR_DATA + 8'd1, 8'hFF, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_READ, tfd_pkg::ADDR_DATA + 8'd1, 8'h00, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_NONE, 8'hFF, 8'hFF, 1'b1, 8'hFF);
    endtask

    // Bytes through both queues: a disabled tick still receives, an enabled
    // tick sends, ticks ignore address and data, an empty queue reads zero.
    task automatic test_byte_paths();
        send_word(tfd_pkg::OP_WRITE, tfd_pkg::ADDR_DATA, 8'h00, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_WRITE, tfd_pkg::ADDR_DATA, 8'hFF, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_TICK, tfd_pkg::ADDR_DATA, 8'h00, 1'b1, 8'hFF);
        send_word(tfd_pkg::OP_WRITE, tfd_pkg::ADDR_CTRL, 8'h01, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_TICK, 8'hFF, 8'hFF, 1'b1, 8'h00);
        send_word(tfd_pkg::OP_TICK, tfd_pkg::ADDR_CTRL, 8'h00, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_TICK, tfd_pkg::ADDR_CTRL, 8'h00, 1'b0, 8'h5A);
        send_word(tfd_pkg::OP_READ, tfd_pkg::ADDR_DATA, 8'h00, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_READ, tfd_pkg::ADDR_DATA, 8'h00, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_READ, tfd_pkg::ADDR_DATA, 8'h00, 1'b0, 8'h00);
    endtask

    // Fill both queues past the widest limit with the port disabled so the
    // ring pointers wrap and the oldest bytes drop, then drain part of each.
    task automatic test_queue_wrap();
        set_fifo_limit(tfd_pkg::LIMIT_RESET);
        send_word(tfd_pkg::OP_WRITE, tfd_pkg::ADDR_CTRL, 8'h00, 1'b0, 8'h00);
        repeat (270) send_word(tfd_pkg::OP_WRITE, tfd_pkg::ADDR_DATA, 8'($urandom),
                               1'b0, 8'h00);
        send_word(tfd_pkg::OP_READ, tfd_pkg::ADDR_TX_COUNT, 8'h00, 1'b0, 8'h00);
        repeat (270) send_word(tfd_pkg::OP_TICK, 8'($urandom), 8'($urandom),
                               1'b1, 8'($urandom));
        send_word(tfd_pkg::OP_READ, tfd_pkg::ADDR_RX_COUNT, 8'h00, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_WRITE, tfd_pkg::ADDR_CTRL, 8'($urandom) | 8'h01,
                  1'b0, 8'h00);
        repeat (140) send_word(tfd_pkg::OP_TICK, 8'($urandom), 8'($urandom),
                               1'b0, 8'($urandom));
        repeat (140) send_word(tfd_pkg::OP_READ, tfd_pkg::ADDR_DATA, 8'($urandom),
                               1'b0, 8'h00);
        send_word(tfd_pkg::OP_READ, tfd_pkg::ADDR_RX_COUNT, 8'h00, 1'b0, 8'h00);
        send_word(tfd_pkg::OP_READ, tfd_pkg::ADDR_TX_COUNT, 8'h00, 1'b0, 8'h00);
    endtask

    // Random traffic across several limits, the narrowest ones included.
    // Limits shrink while the queues still hold bytes, so counts above the
    // new limit are exercised too. One phase runs with no idling at all.
    task automatic test_random_traffic();
        logic [7:0] limits[6];
        limits[0] = 8'd1;
        limits[1] = 8'd2;
        limits[2] = 8'($urandom_range(3, 12));
        limits[3] = tfd_pkg::LIMIT_RESET;
        limits[4] = 8'($urandom_range(13, 254));
        limits[5] = tfd_pkg::LIMIT_RESET;
        foreach (limits[p]) begin
            set_fifo_limit(limits[p]);
            in_gap_max  = (p == 3) ? 0 : 12;
            out_gap_max = (p == 3) ? 0 : 12;
            repeat (105) send_random_word();
        end
        in_gap_max  = 12;
        out_gap_max = 12;
    endtask

    // Hold the output off for a long stretch while words keep coming, so the
    // block fills and stalls its input; then pause the sender until nothing
    // is owed before resuming.
    task automatic test_backpressure();
        set_fifo_limit(8'($urandom_range(4, 32)));
        in_gap_max       = 0;
        hold_off_request = 200;
        repeat (40) send_random_word();
        in_gap_max = 12;
        wait_for_results();
        repeat ($urandom_range(5, 30)) @(posedge i_clk);
        repeat (30) send_random_word();
    endtask

    initial begin : run_limit
        #(CLK_PERIOD * 400_000);
        $display("Some tests failed");
        $finish;
    end

    initial begin : test_sequence
        // Hold every input at a known value before the first edge
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 8'h00;
        i_in_valid    = 1'b0;
        i_operation   = tfd_pkg::OP_NONE;
        i_address     = 8'h00;
        i_write_data  = 8'h00;
        i_rx_valid    = 1'b0;
        i_rx_byte     = 8'h00;
        port_on       = 1'b0;
        rate_sel      = '0;
        fifo_limit    = tfd_pkg::LIMIT_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_register_access();
        test_byte_paths();
        test_queue_wrap();
        test_random_traffic();
        test_backpressure();

        wait_for_results();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/tfd_pkg.sv
sv/tfd_ram.sv
sv/tfd_queue.sv
sv/tty_fifo_device.sv
verif/tty_fifo_device_tb.sv
